// File: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define HKR_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hkr assertion failed");

// condition that must never be true outside reset
`define HKR_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("hkr forbidden condition seen");

`else

`define HKR_ASSERT(label, clk, rst_n, prop)
`define HKR_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/hkr_pkg.sv
// package: types, constants and the uk key code table
`timescale 1ns / 1ps
`default_nettype none

package hkr_pkg;

  localparam int unsigned HkrPortsDefault = 8;
  localparam int unsigned SlotCount       = 6;
  localparam int unsigned ReportBytes     = 8;
  localparam int unsigned PortW           = 3;
  localparam int unsigned InDataW         = 64;
  localparam int unsigned OutDataW        = 24;

  localparam logic [7:0] CapsCode  = 8'h39;
  localparam logic [7:0] TableSize = 8'd60;
  localparam logic [7:0] ShiftMask = 8'h22;
  localparam logic [7:0] PoundChar = 8'hA3;
  localparam logic [7:0] NotChar   = 8'hAC;
  localparam logic [7:0] AtChar    = 8'h40;

  typedef logic [ReportBytes-1:0][7:0] report_t;

  typedef struct packed {
    logic       is_caps;
    logic       is_new;
    logic [7:0] ch;
  } lane_res_t;

  typedef struct packed {
    logic       caps_hit;
    logic       found;
    logic [7:0] ch;
  } merge_res_t;

  // uk layout lookup, codes at or above the table size give zero
  function automatic logic [7:0] key_char_lut(input logic [7:0] code, input logic upper);
    logic [7:0] ch;
    ch = 8'h00;
    if (code inside {[8'd4:8'd29]}) begin
      ch = (upper ? 8'h41 : 8'h61) + (code - 8'd4);
    end else if (code < TableSize) begin
      case (code)
        8'd30:   ch = upper ? 8'h21 : 8'h31;
        8'd31:   ch = upper ? 8'h22 : 8'h32;
        8'd32:   ch = upper ? PoundChar : 8'h33;
        8'd33:   ch = upper ? 8'h24 : 8'h34;
        8'd34:   ch = upper ? 8'h25 : 8'h35;
        8'd35:   ch = upper ? 8'h5E : 8'h36;
        8'd36:   ch = upper ? 8'h26 : 8'h37;
        8'd37:   ch = upper ? 8'h2A : 8'h38;
        8'd38:   ch = upper ? 8'h28 : 8'h39;
        8'd39:   ch = upper ? 8'h29 : 8'h30;
        8'd40:   ch = 8'h0A;
        8'd43:   ch = 8'h20;
        8'd44:   ch = 8'h20;
        8'd45:   ch = upper ? 8'h5F : 8'h2D;
        8'd46:   ch = upper ? 8'h2B : 8'h3D;
        8'd47:   ch = upper ? 8'h7B : 8'h5B;
        8'd48:   ch = upper ? 8'h7D : 8'h5D;
        8'd49:   ch = upper ? 8'h7C : 8'h5C;
        8'd50:   ch = upper ? 8'h7E : 8'h23;
        8'd51:   ch = upper ? 8'h3A : 8'h3B;
        8'd52:   ch = upper ? AtChar : 8'h27;
        8'd53:   ch = upper ? NotChar : 8'h60;
        8'd54:   ch = upper ? 8'h3C : 8'h2C;
        8'd55:   ch = upper ? 8'h3E : 8'h2E;
        8'd56:   ch = upper ? 8'h3F : 8'h2F;
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hkr_lane.sv
// one key slot lane: caps detect, previous report match and character lookup
`timescale 1ns / 1ps
`default_nettype none

module hkr_lane (
  input  logic [7:0]       code_i,
  input  logic             upper_i,
  input  hkr_pkg::report_t prev_i,
  output hkr_pkg::lane_res_t res_o
);
  import hkr_pkg::*;

  logic seen;

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < ReportBytes; i++) begin
      if (prev_i[i] == code_i) begin
        seen = 1'b1;
      end
    end
  end

  assign res_o.is_caps = (code_i == CapsCode);
  assign res_o.is_new  = !seen;
  assign res_o.ch      = key_char_lut(code_i, upper_i);

endmodule

`default_nettype wire

// File: rtl/hkr_merge.sv
// merge of the six lane results in slot order
`timescale 1ns / 1ps
`default_nettype none

module hkr_merge (
  input  hkr_pkg::lane_res_t [hkr_pkg::SlotCount-1:0] lanes_i,
  output hkr_pkg::merge_res_t                         res_o
);
  import hkr_pkg::*;

  logic       stop;
  logic       found;
  logic [7:0] ch;

  // first caps-lock slot ends the scan, last new slot before it wins
  always_comb begin
    stop  = 1'b0;
    found = 1'b0;
    ch    = 8'h00;
    for (int i = 0; i < SlotCount; i++) begin
      if (!stop) begin
        if (lanes_i[i].is_caps) begin
          stop = 1'b1;
        end else if (lanes_i[i].is_new) begin
          found = 1'b1;
          ch    = lanes_i[i].ch;
        end
      end
    end
  end

  assign res_o.caps_hit = stop;
  assign res_o.found    = found;
  assign res_o.ch       = ch;

endmodule

`default_nettype wire

// File: rtl/hid_keyboard_report_to_ascii.sv
// top level: boot keyboard report to uk ascii character, per-port caps lock
//
// slave stream: one word per boot keyboard report, port number on tuser,
// the eight report bytes on tdata. master stream: one word per report with
// the decoded character, flags and the modifier byte.
// six lanes compare the key slots against the stored previous report and
// look up their characters in parallel; a merge stage picks the result.
// the result word is registered in the output register, or in the skid register.
// throughput: one report per cycle when s_axis_tready is high; caps bits and
// previous report are updated at the accepting edge, so the next report sees them
// at once. a two-word output buffer (output register plus skid register) lets a
// report be taken while a result waits; s_axis_tready drops only when both
// words are full.
// reset clears the caps bits, the previous report and the output buffer.
// reports for a port at or above PORTS leave the caps bits and previous report unchanged.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hid_keyboard_report_to_ascii #(
  parameter int unsigned PORTS = hkr_pkg::HkrPortsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // modifier_bits, reserved_byte, key_slot_1 .. key_slot_6
  input  logic [hkr_pkg::InDataW-1:0]  s_axis_tdata_i,
  // port
  input  logic [hkr_pkg::PortW-1:0]    s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // key_char, new_key_found, report_accepted, caps_lock_on, modifiers_out, zero pad
  output logic [hkr_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import hkr_pkg::*;

  logic [PORTS-1:0] caps_q, caps_d;
  report_t          prev_q;
  report_t          report;

  logic                  in_acc;
  logic                  port_ok;
  logic                  caps_cur;
  logic                  upper;
  lane_res_t [SlotCount-1:0] lanes;
  merge_res_t            merged;
  logic [OutDataW-1:0]   word;

  logic                out_valid_q, skid_valid_q;
  logic [OutDataW-1:0] out_q, skid_q;
  logic                pop;

  assign report  = report_t'(s_axis_tdata_i);
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;
  assign port_ok = 32'(s_axis_tuser_i) < PORTS;

  always_comb begin
    caps_cur = 1'b0;
    for (int p = 0; p < PORTS; p++) begin
      if (32'(s_axis_tuser_i) == p) begin
        caps_cur = caps_q[p];
      end
    end
  end

  assign upper = caps_cur || ((report[0] & ShiftMask) != 8'h00);

  for (genvar g = 0; g < SlotCount; g++) begin : g_lane
    hkr_lane u_lane (
      .code_i  (report[2+g]),
      .upper_i (upper),
      .prev_i  (prev_q),
      .res_o   (lanes[g])
    );
  end

  hkr_merge u_merge (
    .lanes_i (lanes),
    .res_o   (merged)
  );

  always_comb begin
    word = '0;
    word[18:11] = report[0];
    if (port_ok) begin
      word[7:0] = merged.ch;
      word[8]   = merged.found;
      word[9]   = !merged.caps_hit;
      word[10]  = caps_cur ^ merged.caps_hit;
    end
  end

  always_comb begin
    for (int p = 0; p < PORTS; p++) begin
      caps_d[p] = caps_q[p] ^ (in_acc && port_ok && merged.caps_hit &&
                               (32'(s_axis_tuser_i) == p));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caps_q <= '0;
      prev_q <= '0;
    end else begin
      caps_q <= caps_d;
      if (in_acc && port_ok && !merged.caps_hit) begin
        prev_q <= report;
      end
    end
  end

  // output register plus skid register
  assign pop             = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = !skid_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc;
        end
      end else if (in_acc) begin
        if (!out_valid_q) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_acc) begin
        out_q <= word;
      end
    end else if (in_acc) begin
      if (!out_valid_q) begin
        out_q <= word;
      end else begin
        skid_q <= word;
      end
    end
  end

  `HKR_ASSERT(a_skid_needs_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `HKR_ASSERT(a_caps_only_on_accept, clk_i, rst_ni, !in_acc |=> $stable(caps_q))
  `HKR_ASSERT(a_prev_only_on_accept, clk_i, rst_ni, !in_acc |=> $stable(prev_q))
  `HKR_ASSERT(a_bad_port_no_state, clk_i, rst_ni,
              (in_acc && !port_ok) |=> ($stable(caps_q) && $stable(prev_q)))

endmodule

`default_nettype wire
